// File: design/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define IRRP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define IRRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define IRRP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define IRRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: design/irrp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package irrp_pkg;

    localparam int JOB_ADDR_W   = 20;
    localparam int JOB_CNT_W    = 21;
    localparam int RESULT_LIMIT = 9;

    localparam logic [1:0] REG_CHANNEL_CODE       = 2'd0;
    localparam logic [1:0] REG_LARGE_MEMORY       = 2'd1;
    localparam logic [1:0] REG_POST_TRIGGER_COUNT = 2'd2;
    localparam logic [1:0] REG_RING_START_ADDRESS = 2'd3;

    localparam logic [2:0] CODE_CLAMP = 3'd4;

    typedef struct packed {
        logic [2:0]  channel_code;
        logic        large_memory;
        logic [23:0] post_trigger_count;
        logic [23:0] ring_start_address;
    } t_cfg;

    typedef struct packed {
        logic                  skip;
        logic signed [24:0]    first;
        logic signed [24:0]    last;
        logic [JOB_ADDR_W-1:0] addr;
        logic [JOB_CNT_W-1:0]  count;
    } t_job;

    function automatic logic [2:0] eff_code(input logic [2:0] code);
        return (code > CODE_CLAMP) ? CODE_CLAMP : code;
    endfunction

endpackage

`default_nettype wire

// File: design/irrp_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface irrp_req_if;
    logic               valid;
    logic               ready;
    logic [3:0]         channel;
    logic               channel_enabled;
    logic               start_given;
    logic signed [31:0] start_index;
    logic               end_given;
    logic signed [31:0] end_index;

    modport source (
        output valid, channel, channel_enabled, start_given, start_index,
               end_given, end_index,
        input  ready
    );
    modport sink (
        input  valid, channel, channel_enabled, start_given, start_index,
               end_given, end_index,
        output ready
    );
endinterface

interface irrp_rsp_if;
    logic               valid;
    logic               ready;
    logic [17:0]        chunk_address;
    logic [14:0]        chunk_samples;
    logic signed [24:0] first_clamped;
    logic signed [24:0] last_clamped;
    logic               skipped;
    logic               final_chunk;

    modport source (
        output valid, chunk_address, chunk_samples, first_clamped, last_clamped,
               skipped, final_chunk,
        input  ready
    );
    modport sink (
        input  valid, chunk_address, chunk_samples, first_clamped, last_clamped,
               skipped, final_chunk,
        output ready
    );
endinterface

`default_nettype wire

// File: design/interleaved_ring_readout_planner.sv
// interleaved ring readout planner
// i_req carries one readout request per item (channel, enable, optional start
// and end index); o_rsp returns one item per memory chunk, the last one marked
// final_chunk, or a single skipped item for a disabled channel or empty range
// registers are to be written over the apb port while no request is in flight,
// which the block does not enforce; a request is taken only while the front
// end is idle; the front end reduces the ring start address by a reciprocal
// multiply and one correction, clamps the indices and forms the start address,
// and takes a new request only once its job is pushed into the queue; chunks
// follow one a cycle from the back end while the receiver takes them, and the
// back end spends a step of its own fetching each job from the queue
// a two-entry job queue lets the front end plan the next request while the
// back end is still emitting chunks
// a stalled receiver holds the output register; the back end and then the
// queue fill, after which i_req.ready stays low
// reset empties the queue and output register and loads the register defaults
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module interleaved_ring_readout_planner #(
    parameter int LARGE_WORDS = 262144,
    parameter int SMALL_WORDS = 65536,
    parameter int MAX_CHUNK   = 32767
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    irrp_req_if.sink    i_req,
    irrp_rsp_if.source  o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import irrp_pkg::*;

    t_cfg r_cfg;
    t_job w_fjob, w_qjob;
    logic w_push, w_full, w_qvalid, w_pop;
    logic w_wr;
    logic w_req_acc, w_skip_out, w_skip_ok;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.channel_code       <= 3'd0;
            r_cfg.large_memory       <= 1'b1;
            r_cfg.post_trigger_count <= 24'd0;
            r_cfg.ring_start_address <= 24'd0;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_CHANNEL_CODE:       r_cfg.channel_code       <= pwdata[2:0];
                REG_LARGE_MEMORY:       r_cfg.large_memory       <= pwdata[0];
                REG_POST_TRIGGER_COUNT: r_cfg.post_trigger_count <= pwdata[23:0];
                REG_RING_START_ADDRESS: r_cfg.ring_start_address <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_CHANNEL_CODE:       prdata = {29'd0, r_cfg.channel_code};
            REG_LARGE_MEMORY:       prdata = {31'd0, r_cfg.large_memory};
            REG_POST_TRIGGER_COUNT: prdata = {8'd0, r_cfg.post_trigger_count};
            REG_RING_START_ADDRESS: prdata = {8'd0, r_cfg.ring_start_address};
            default:                prdata = 32'd0;
        endcase
    end

    irrp_front #(
        .LARGE_WORDS (LARGE_WORDS),
        .SMALL_WORDS (SMALL_WORDS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cfg   (r_cfg),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_fjob)
    );

    irrp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_fjob),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_qvalid),
        .o_job   (w_qjob)
    );

    irrp_back #(
        .LARGE_WORDS (LARGE_WORDS),
        .SMALL_WORDS (SMALL_WORDS),
        .MAX_CHUNK   (MAX_CHUNK)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_qvalid (w_qvalid),
        .i_job    (w_qjob),
        .o_pop    (w_pop),
        .o_rsp    (o_rsp)
    );

    assign w_req_acc  = i_req.valid && i_req.ready;
    assign w_skip_out = o_rsp.valid && o_rsp.skipped;
    assign w_skip_ok  = o_rsp.final_chunk && (o_rsp.chunk_samples == 15'd0);

    `IRRP_ASSERT_IMPL(a_push_not_full, i_clk, i_rst_n, w_push, !w_full)
    `IRRP_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_req_acc, !i_req.ready)
    `IRRP_ASSERT_IMPL(a_skip_is_final, i_clk, i_rst_n, w_skip_out, w_skip_ok)
    `IRRP_ASSERT_IMPL(a_pop_has_job, i_clk, i_rst_n, w_pop, w_qvalid)

endmodule

`default_nettype wire

// File: design/irrp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module irrp_front #(
    parameter int LARGE_WORDS = 262144,
    parameter int SMALL_WORDS = 65536
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    irrp_req_if.sink      i_req,
    input  irrp_pkg::t_cfg i_cfg,
    input  logic          i_full,
    output logic          o_push,
    output irrp_pkg::t_job o_job
);
    import irrp_pkg::*;

    localparam int MAX_WORDS = (LARGE_WORDS > SMALL_WORDS) ? LARGE_WORDS : SMALL_WORDS;
    localparam int MIN_WORDS = (LARGE_WORDS < SMALL_WORDS) ? LARGE_WORDS : SMALL_WORDS;
    localparam int MEM_W     = $clog2(MAX_WORDS + 1);
    localparam int RCP_W     = 25 - $clog2(MIN_WORDS);
    localparam int PROD_W    = 24 + RCP_W;
    localparam int RCP_LARGE = (1 << 24) / LARGE_WORDS;
    localparam int RCP_SMALL = (1 << 24) / SMALL_WORDS;

    typedef enum logic [5:0] {
        F_IDLE  = 6'b000001,
        F_RCP   = 6'b000010,
        F_REM   = 6'b000100,
        F_CLAMP = 6'b001000,
        F_ADDR  = 6'b010000,
        F_PUSH  = 6'b100000
    } t_fstate;

    t_fstate r_state, n_state;

    logic [3:0]         r_chan;
    logic               r_en;
    logic               r_sg;
    logic signed [31:0] r_sidx;
    logic               r_eg;
    logic signed [31:0] r_eidx;
    logic [23:0]        r_red, n_red;
    logic [RCP_W-1:0]   r_q, n_q;
    logic               r_dis;
    logic signed [24:0] r_first, r_last;
    logic [MEM_W-1:0]   r_offs;
    t_job               r_job;

    logic [2:0]         w_code;
    logic [4:0]         w_active;
    logic [MEM_W-1:0]   w_mem;
    logic [MEM_W-1:0]   w_per;
    logic [RCP_W-1:0]   w_rcp;
    logic [PROD_W-1:0]  w_prod;
    logic [23:0]        w_qm;
    logic               w_dis;
    logic signed [32:0] w_min, w_max, w_sreq, w_ereq, w_first, w_last;
    logic [MEM_W:0]     w_sum, w_addr;
    logic signed [25:0] w_cnt;
    logic               w_empty;
    logic               w_accept;

    assign w_code   = eff_code(i_cfg.channel_code);
    assign w_active = 5'd1 << w_code;
    assign w_mem    = i_cfg.large_memory ? MEM_W'(LARGE_WORDS) : MEM_W'(SMALL_WORDS);
    assign w_per    = w_mem >> w_code;
    assign w_dis    = !r_en || ({1'b0, r_chan} >= w_active);

    // ring start reduced modulo memory size by reciprocal multiply
    assign w_rcp  = i_cfg.large_memory ? RCP_W'(RCP_LARGE) : RCP_W'(RCP_SMALL);
    assign w_prod = PROD_W'(r_red) * PROD_W'(w_rcp);
    assign w_qm   = 24'(r_q) * 24'(w_mem);

    assign i_req.ready = (r_state == F_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;

    // window clamp
    always_comb begin
        w_min  = $signed({9'd0, i_cfg.post_trigger_count}) - $signed(33'(w_per));
        w_max  = $signed({9'd0, i_cfg.post_trigger_count}) - 33'sd1;
        w_sreq = $signed({r_sidx[31], r_sidx});
        w_ereq = $signed({r_eidx[31], r_eidx});
        w_first = w_min;
        if (r_sg) begin
            if (w_sreq < w_min) begin
                w_first = w_min;
            end else if (w_sreq > w_max) begin
                w_first = w_max;
            end else begin
                w_first = w_sreq;
            end
        end
        w_last = w_max;
        if (r_eg) begin
            if (w_ereq < w_min) begin
                w_last = w_min;
            end else if (w_ereq > w_max) begin
                w_last = w_max;
            end else begin
                w_last = w_ereq;
            end
        end
    end

    // start address and length
    always_comb begin
        w_sum = (MEM_W + 1)'(r_red) + (MEM_W + 1)'(r_chan)
              + ((MEM_W + 1)'(r_offs) << w_code);
        if (w_sum >= {1'b0, w_mem}) begin
            w_addr = w_sum - {1'b0, w_mem};
        end else begin
            w_addr = w_sum;
        end
        w_cnt   = 26'(r_last) - 26'(r_first) + 26'sd1;
        w_empty = (r_last < r_first);
    end

    always_comb begin
        n_state = r_state;
        n_red   = r_red;
        n_q     = r_q;
        case (r_state)
            F_IDLE: begin
                if (w_accept) begin
                    n_red   = i_cfg.ring_start_address;
                    n_state = F_RCP;
                end
            end
            F_RCP: begin
                n_q     = w_prod[PROD_W-1:24];
                n_state = F_REM;
            end
            F_REM: begin
                n_red   = r_red - w_qm;
                n_state = F_CLAMP;
            end
            F_CLAMP: begin
                if (r_red >= 24'(w_mem)) begin
                    n_red = r_red - 24'(w_mem);
                end
                n_state = F_ADDR;
            end
            F_ADDR:  n_state = F_PUSH;
            F_PUSH: begin
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_red <= n_red;
        r_q   <= n_q;
        if (w_accept) begin
            r_chan <= i_req.channel;
            r_en   <= i_req.channel_enabled;
            r_sg   <= i_req.start_given;
            r_sidx <= i_req.start_index;
            r_eg   <= i_req.end_given;
            r_eidx <= i_req.end_index;
        end
        if (r_state == F_CLAMP) begin
            r_dis   <= w_dis;
            r_first <= 25'(w_first);
            r_last  <= 25'(w_last);
            r_offs  <= MEM_W'(w_first - w_min);
        end
        if (r_state == F_ADDR) begin
            r_job.skip  <= r_dis || w_empty;
            r_job.first <= r_dis ? 25'sd0 : r_first;
            r_job.last  <= r_dis ? 25'sd0 : r_last;
            r_job.addr  <= JOB_ADDR_W'(w_addr);
            r_job.count <= JOB_CNT_W'(w_cnt);
        end
    end

    assign o_push = (r_state == F_PUSH) && !i_full;
    assign o_job  = r_job;

endmodule

`default_nettype wire

// File: design/irrp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module irrp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  irrp_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output irrp_pkg::t_job o_job
);
    import irrp_pkg::*;

    t_job       r_slot [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_slot[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= !r_wr;
            end
            if (w_pop) begin
                r_rd <= !r_rd;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr] <= i_job;
        end
    end

endmodule

`default_nettype wire

// File: design/irrp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module irrp_back #(
    parameter int LARGE_WORDS = 262144,
    parameter int SMALL_WORDS = 65536,
    parameter int MAX_CHUNK   = 32767
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  irrp_pkg::t_cfg i_cfg,
    input  logic           i_qvalid,
    input  irrp_pkg::t_job i_job,
    output logic           o_pop,
    irrp_rsp_if.source     o_rsp
);
    import irrp_pkg::*;

    localparam int MAX_WORDS = (LARGE_WORDS > SMALL_WORDS) ? LARGE_WORDS : SMALL_WORDS;
    localparam int MEM_W     = $clog2(MAX_WORDS + 1);
    localparam int CH_W      = $clog2(MAX_CHUNK + 1);

    // address advance of one full chunk, per channel code
    localparam logic [MEM_W-1:0] STEP_LARGE [5] = '{
        MEM_W'((MAX_CHUNK * 1) % LARGE_WORDS),
        MEM_W'((MAX_CHUNK * 2) % LARGE_WORDS),
        MEM_W'((MAX_CHUNK * 4) % LARGE_WORDS),
        MEM_W'((MAX_CHUNK * 8) % LARGE_WORDS),
        MEM_W'((MAX_CHUNK * 16) % LARGE_WORDS)
    };
    localparam logic [MEM_W-1:0] STEP_SMALL [5] = '{
        MEM_W'((MAX_CHUNK * 1) % SMALL_WORDS),
        MEM_W'((MAX_CHUNK * 2) % SMALL_WORDS),
        MEM_W'((MAX_CHUNK * 4) % SMALL_WORDS),
        MEM_W'((MAX_CHUNK * 8) % SMALL_WORDS),
        MEM_W'((MAX_CHUNK * 16) % SMALL_WORDS)
    };

    logic                  r_busy, n_busy;
    logic                  r_skip, n_skip;
    logic signed [24:0]    r_first, n_first;
    logic signed [24:0]    r_last, n_last;
    logic [MEM_W-1:0]      r_addr, n_addr;
    logic [JOB_CNT_W-1:0]  r_rem, n_rem;
    logic [3:0]            r_k, n_k;

    logic                  r_ovalid, n_ovalid;
    logic [17:0]           r_oaddr, n_oaddr;
    logic [14:0]           r_osamps, n_osamps;
    logic signed [24:0]    r_ofirst, n_ofirst;
    logic signed [24:0]    r_olast, n_olast;
    logic                  r_oskip, n_oskip;
    logic                  r_ofin, n_ofin;

    logic [2:0]            w_code;
    logic [MEM_W-1:0]      w_mem;
    logic [MEM_W-1:0]      w_step;
    logic [MEM_W:0]        w_nsum;
    logic [CH_W-1:0]       w_samps;
    logic [JOB_CNT_W-1:0]  w_left;
    logic                  w_fin;
    logic                  w_free;

    assign w_code = eff_code(i_cfg.channel_code);
    assign w_mem  = i_cfg.large_memory ? MEM_W'(LARGE_WORDS) : MEM_W'(SMALL_WORDS);
    assign w_step = i_cfg.large_memory ? STEP_LARGE[w_code] : STEP_SMALL[w_code];
    assign w_nsum = {1'b0, r_addr} + {1'b0, w_step};
    assign w_free = !r_ovalid || o_rsp.ready;

    assign w_samps = (r_rem < JOB_CNT_W'(MAX_CHUNK)) ? CH_W'(r_rem) : CH_W'(MAX_CHUNK);
    assign w_left  = r_rem - JOB_CNT_W'(w_samps);
    assign w_fin   = (w_left == '0) || (r_k == 4'(RESULT_LIMIT - 1));

    always_comb begin
        n_busy   = r_busy;
        n_skip   = r_skip;
        n_first  = r_first;
        n_last   = r_last;
        n_addr   = r_addr;
        n_rem    = r_rem;
        n_k      = r_k;
        n_ovalid = r_ovalid;
        n_oaddr  = r_oaddr;
        n_osamps = r_osamps;
        n_ofirst = r_ofirst;
        n_olast  = r_olast;
        n_oskip  = r_oskip;
        n_ofin   = r_ofin;
        o_pop    = 1'b0;
        if (w_free) begin
            n_ovalid = 1'b0;
        end
        if (!r_busy) begin
            if (i_qvalid) begin
                o_pop   = 1'b1;
                n_busy  = 1'b1;
                n_skip  = i_job.skip;
                n_first = i_job.first;
                n_last  = i_job.last;
                n_addr  = MEM_W'(i_job.addr);
                n_rem   = i_job.count;
                n_k     = 4'd0;
            end
        end else if (w_free) begin
            n_ovalid = 1'b1;
            n_ofirst = r_first;
            n_olast  = r_last;
            if (r_skip) begin
                n_oaddr  = 18'd0;
                n_osamps = 15'd0;
                n_oskip  = 1'b1;
                n_ofin   = 1'b1;
                n_busy   = 1'b0;
            end else begin
                n_oaddr  = 18'(r_addr);
                n_osamps = 15'(w_samps);
                n_oskip  = 1'b0;
                n_ofin   = w_fin;
                n_rem    = w_left;
                n_k      = r_k + 4'd1;
                if (w_nsum >= {1'b0, w_mem}) begin
                    n_addr = MEM_W'(w_nsum - {1'b0, w_mem});
                end else begin
                    n_addr = MEM_W'(w_nsum);
                end
                if (w_fin) begin
                    n_busy = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_skip   <= n_skip;
        r_first  <= n_first;
        r_last   <= n_last;
        r_addr   <= n_addr;
        r_rem    <= n_rem;
        r_k      <= n_k;
        r_oaddr  <= n_oaddr;
        r_osamps <= n_osamps;
        r_ofirst <= n_ofirst;
        r_olast  <= n_olast;
        r_oskip  <= n_oskip;
        r_ofin   <= n_ofin;
    end

    assign o_rsp.valid         = r_ovalid;
    assign o_rsp.chunk_address = r_oaddr;
    assign o_rsp.chunk_samples = r_osamps;
    assign o_rsp.first_clamped = r_ofirst;
    assign o_rsp.last_clamped  = r_olast;
    assign o_rsp.skipped       = r_oskip;
    assign o_rsp.final_chunk   = r_ofin;

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import irrp_pkg::*;

    localparam int LARGE_WORDS = 262144;
    localparam int SMALL_WORDS = 65536;
    localparam int MAX_CHUNK   = 32767;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASES      = 11;
    localparam int PHASE_ITEMS = 31;

    typedef struct packed {
        logic [3:0]  channel;
        logic        enabled;
        logic        start_given;
        logic [31:0] start_index;
        logic        end_given;
        logic [31:0] end_index;
    } readout_req_t;

    typedef struct packed {
        logic [17:0] address;
        logic [14:0] samples;
        logic [24:0] first;
        logic [24:0] last;
        logic        skipped;
        logic        final_chunk;
    } chunk_t;

    typedef struct {
        bit           is_cfg;
        logic [1:0]   reg_idx;
        logic [31:0]  value;
        readout_req_t item;
        bit           has_want;
        chunk_t       want;
    } stim_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    irrp_req_if req ();
    irrp_rsp_if rsp ();

    interleaved_ring_readout_planner dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_cfg      plan_cfg;
    chunk_t    pending_chunks[$];
    stim_row_t stim_rows[$];
    int        mismatch_count = 0;
    int        idle_cycles = 0;
    bit        no_idle = 1'b0;
    bit        hold_rsp = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string field, input longint got, input longint want);
        mismatch_count++;
        if (mismatch_count <= 50) begin
            $display("mismatch %s: got %0h want %0h", field, got, want);
        end
    endtask

    function automatic void readable_window(output longint words, output longint active,
                                            output longint lo, output longint hi);
        logic [2:0] code;
        code   = (plan_cfg.channel_code > CODE_CLAMP) ? CODE_CLAMP : plan_cfg.channel_code;
        words  = plan_cfg.large_memory ? LARGE_WORDS : SMALL_WORDS;
        active = longint'(1) << code;
        hi     = longint'(plan_cfg.post_trigger_count) - 1;
        lo     = longint'(plan_cfg.post_trigger_count) - words / active;
    endfunction

    task automatic plan_chunks(input readout_req_t r);
        longint words, active, lo, hi, first, last, count, addr, left, take;
        int     k;
        chunk_t c;
        readable_window(words, active, lo, hi);
        c = '0;
        c.skipped = 1'b1;
        c.final_chunk = 1'b1;
        if (!r.enabled || longint'(r.channel) >= active) begin
            pending_chunks.push_back(c);
            return;
        end
        first = r.start_given ? longint'($signed(r.start_index)) : lo;
        last  = r.end_given ? longint'($signed(r.end_index)) : hi;
        if (first < lo) first = lo;
        if (first > hi) first = hi;
        if (last < lo) last = lo;
        if (last > hi) last = hi;
        count = last - first + 1;
        c.first = 25'(first);
        c.last  = 25'(last);
        if (count <= 0) begin
            pending_chunks.push_back(c);
            return;
        end
        addr = (longint'(plan_cfg.ring_start_address) % words + longint'(r.channel)
                + (first - lo) * active) % words;
        left = count;
        k = 0;
        c.skipped = 1'b0;
        while (left > 0 && k < RESULT_LIMIT) begin
            take = (left < MAX_CHUNK) ? left : MAX_CHUNK;
            left -= take;
            c.address = 18'(addr);
            c.samples = 15'(take);
            c.final_chunk = (left == 0) || (k == RESULT_LIMIT - 1);
            pending_chunks.push_back(c);
            addr = (addr + take * active) % words;
            k++;
        end
    endtask

    function automatic chunk_t skip_chunk(input logic [24:0] first, input logic [24:0] last);
        chunk_t c;
        c = '0;
        c.first = first;
        c.last = last;
        c.skipped = 1'b1;
        c.final_chunk = 1'b1;
        return c;
    endfunction

    task automatic add_cfg(input logic [1:0] idx, input logic [31:0] value);
        stim_row_t row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.reg_idx = idx;
        row.value = value;
        stim_rows.push_back(row);
    endtask

    task automatic add_req(input logic [3:0] ch, input logic en, input logic sg,
                           input logic [31:0] s, input logic eg, input logic [31:0] e,
                           input bit has_want, input chunk_t want);
        stim_row_t row;
        row = '{default: '0};
        row.item = '{ch, en, sg, s, eg, e};
        row.has_want = has_want;
        row.want = want;
        stim_rows.push_back(row);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] want;
        case (idx)
            REG_CHANNEL_CODE:       want = value & 32'h7;
            REG_LARGE_MEMORY:       want = value & 32'h1;
            REG_POST_TRIGGER_COUNT: want = value & 32'hFF_FFFF;
            default:                want = value & 32'hFF_FFFF;
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_CHANNEL_CODE:       plan_cfg.channel_code = want[2:0];
            REG_LARGE_MEMORY:       plan_cfg.large_memory = want[0];
            REG_POST_TRIGGER_COUNT: plan_cfg.post_trigger_count = want[23:0];
            default:                plan_cfg.ring_start_address = want[23:0];
        endcase
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) report_mismatch("register readback", prdata, want);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        req.valid <= 1'b0;
        while (pending_chunks.size() != 0) @(posedge i_clk);
    endtask

    task automatic drive_req(input readout_req_t r, input bit has_want, input chunk_t want);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req.valid           <= 1'b1;
        req.channel         <= r.channel;
        req.channel_enabled <= r.enabled;
        req.start_given     <= r.start_given;
        req.start_index     <= r.start_index;
        req.end_given       <= r.end_given;
        req.end_index       <= r.end_index;
        do @(posedge i_clk); while (!req.ready);
        if (has_want) pending_chunks.push_back(want);
        else plan_chunks(r);
    endtask

    function automatic logic [31:0] pick_index(input longint lo, input longint hi);
        longint edge_base;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return 32'(lo + $urandom_range(0, 32'(hi - lo)));
            6: begin
                edge_base = $urandom_range(0, 1) ? lo : hi;
                return 32'(edge_base + $urandom_range(0, 4) - 2);
            end
            7: return $urandom;
            default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        endcase
    endfunction

    function automatic readout_req_t random_req();
        readout_req_t r;
        longint words, active, lo, hi;
        readable_window(words, active, lo, hi);
        r.channel = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, 32'(active - 1)))
                                               : 4'($urandom_range(0, 15));
        r.enabled = $urandom_range(0, 9) != 0;
        r.start_given = $urandom_range(0, 3) != 0;
        r.end_given = $urandom_range(0, 3) != 0;
        r.start_index = pick_index(lo, hi);
        if ($urandom_range(0, 9) < 6) r.end_index = r.start_index + $urandom_range(0, 70000);
        else r.end_index = pick_index(lo, hi);
        return r;
    endfunction

    task automatic random_config();
        logic [31:0] ptc, rsa;
        case ($urandom_range(0, 4))
            0:       ptc = 0;
            1:       ptc = 32'hFF_FFFF;
            2:       ptc = $urandom_range(0, 300000);
            3:       ptc = $urandom & 32'hFF_FFFF;
            default: ptc = $urandom_range(1, 40);
        endcase
        case ($urandom_range(0, 3))
            0:       rsa = 0;
            1:       rsa = 32'hFF_FFFF;
            default: rsa = $urandom & 32'hFF_FFFF;
        endcase
        write_reg(REG_CHANNEL_CODE, $urandom_range(0, 7));
        write_reg(REG_LARGE_MEMORY, $urandom_range(0, 1));
        write_reg(REG_POST_TRIGGER_COUNT, ptc);
        write_reg(REG_RING_START_ADDRESS, rsa);
    endtask

    task automatic check_chunk();
        chunk_t got, want;
        got.address     = rsp.chunk_address;
        got.samples     = rsp.chunk_samples;
        got.first       = rsp.first_clamped;
        got.last        = rsp.last_clamped;
        got.skipped     = rsp.skipped;
        got.final_chunk = rsp.final_chunk;
        if (pending_chunks.size() == 0) begin
            report_mismatch("unexpected item", got.address, 0);
            return;
        end
        want = pending_chunks.pop_front();
        if (got.address !== want.address)
            report_mismatch("chunk_address", got.address, want.address);
        if (got.samples !== want.samples)
            report_mismatch("chunk_samples", got.samples, want.samples);
        if (got.first !== want.first)
            report_mismatch("first_clamped", got.first, want.first);
        if (got.last !== want.last)
            report_mismatch("last_clamped", got.last, want.last);
        if (got.skipped !== want.skipped)
            report_mismatch("skipped", got.skipped, want.skipped);
        if (got.final_chunk !== want.final_chunk)
            report_mismatch("final_chunk", got.final_chunk, want.final_chunk);
    endtask

    initial begin : rsp_sink
        int stall;
        rsp.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_rsp) begin
                rsp.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_rsp = 1'b0;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 16);
                if (stall > 0) begin
                    rsp.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            rsp.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp.valid);
            check_chunk();
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)
            || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        req.valid           <= 1'b0;
        req.channel         <= '0;
        req.channel_enabled <= 1'b0;
        req.start_given     <= 1'b0;
        req.start_index     <= '0;
        req.end_given       <= 1'b0;
        req.end_index       <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        i_rst_n <= 1'b0;
        plan_cfg = '{channel_code: 3'd0, large_memory: 1'b1,
                     post_trigger_count: 24'd0, ring_start_address: 24'd0};

        // reset settings: one channel, large memory, window ends at -1
        add_req(4'd0, 1'b0, 1'b0, 0, 1'b0, 0, 1'b1, skip_chunk(0, 0));
        add_req(4'd15, 1'b1, 1'b0, 0, 1'b0, 0, 1'b1, skip_chunk(0, 0));
        add_req(4'd0, 1'b1, 1'b0, 0, 1'b0, 0, 1'b0, '0);
        add_req(4'd0, 1'b1, 1'b1, 10, 1'b1, -100, 1'b1, skip_chunk(-1, -100));
        add_req(4'd0, 1'b1, 1'b1, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF, 1'b0, '0);
        // sixteen channels, small memory, all-ones count and start address
        add_cfg(REG_CHANNEL_CODE, 7);
        add_cfg(REG_LARGE_MEMORY, 0);
        add_cfg(REG_POST_TRIGGER_COUNT, 32'hFF_FFFF);
        add_cfg(REG_RING_START_ADDRESS, 32'hFF_FFFF);
        add_req(4'd15, 1'b1, 1'b0, 0, 1'b0, 0, 1'b0, '0);
        add_req(4'd15, 1'b0, 1'b1, 5, 1'b1, 9, 1'b1, skip_chunk(0, 0));
        add_req(4'd3, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b0, 0, 1'b0, '0);
        add_req(4'd3, 1'b1, 1'b0, 0, 1'b1, 32'h8000_0000, 1'b0, '0);
        add_req(4'd9, 1'b1, 1'b1, 16777214, 1'b1, 16773119, 1'b1,
                skip_chunk(16777214, 16773119));
        add_req(4'd0, 1'b1, 1'b1, -1, 1'b1, -1, 1'b0, '0);
        add_cfg(REG_CHANNEL_CODE, 4);
        add_cfg(REG_LARGE_MEMORY, 1);
        add_cfg(REG_POST_TRIGGER_COUNT, 5000);
        add_req(4'd15, 1'b1, 1'b0, 0, 1'b0, 0, 1'b0, '0);
        // two channels, range just over one chunk
        add_cfg(REG_CHANNEL_CODE, 1);
        add_cfg(REG_LARGE_MEMORY, 0);
        add_cfg(REG_POST_TRIGGER_COUNT, 40000);
        add_cfg(REG_RING_START_ADDRESS, 0);
        add_req(4'd1, 1'b1, 1'b0, 0, 1'b0, 0, 1'b0, '0);
        add_req(4'd2, 1'b1, 1'b0, 0, 1'b0, 0, 1'b1, skip_chunk(0, 0));
        add_req(4'd0, 1'b1, 1'b1, 39999, 1'b1, 39999, 1'b0, '0);
        add_req(4'd1, 1'b1, 1'b1, 0, 1'b1, 32'h7FFF_FFFF, 1'b0, '0);
        add_cfg(REG_CHANNEL_CODE, 5);
        add_req(4'd12, 1'b1, 1'b0, 0, 1'b0, 0, 1'b0, '0);
        add_cfg(REG_CHANNEL_CODE, 6);
        add_req(4'd5, 1'b1, 1'b1, -5, 1'b0, 0, 1'b0, '0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[i]) begin
            if (stim_rows[i].is_cfg) begin
                wait_idle();
                write_reg(stim_rows[i].reg_idx, stim_rows[i].value);
            end else begin
                drive_req(stim_rows[i].item, stim_rows[i].has_want, stim_rows[i].want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            no_idle = 1'b0;
            random_config();
            if (p == 2) begin
                no_idle = 1'b1;
                hold_rsp = 1'b1;
            end else if (p % 4 == 1) begin
                no_idle = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) drive_req(random_req(), 1'b0, '0);
        end

        wait_idle();
        no_idle = 1'b0;
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0 && pending_chunks.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
